### design/afc_pkg.sv
// Shared types and constants for the box frustum culling pipeline.
// Depends on nothing; every other design file imports it.
package afc_pkg;

	// Matrix register format: four signed 16-bit entries per row, column 0 lowest.
	localparam int MAT_W     = 16;
	localparam int ROWS      = 4;
	localparam int COLS      = 4;
	localparam int AXES      = 3;
	localparam int CORNERS   = 8;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 8;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW0 = 8'd0,
		REG_ROW1 = 8'd1,
		REG_ROW2 = 8'd2,
		REG_ROW3 = 8'd3
	} reg_idx_t;

	// Row 3 of the matrix produces w.
	localparam int ROW_W = 3;

	typedef logic [CFG_W-1:0] row_t;
	typedef row_t [ROWS-1:0] mat_t;

	// Per-stage load enables handed from the pipeline control to the datapath.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} afc_adv_t;

	// Pick one signed entry out of a packed matrix row.
	function automatic logic signed [MAT_W-1:0] mat_entry(input row_t row, input int col);
		mat_entry = $signed(row[col*MAT_W +: MAT_W]);
	endfunction

endpackage

### design/afc_cfg.sv
// Matrix register file, written through the configuration channel.
// Depends on afc_pkg.
module afc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [afc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [afc_pkg::CFG_W-1:0]     cfg_data,
	output afc_pkg::mat_t                 matrix
);
	import afc_pkg::*;

	mat_t matrix_q;

	// Writes to indexes past the last row are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROW0: matrix_q[0] <= cfg_data;
				REG_ROW1: matrix_q[1] <= cfg_data;
				REG_ROW2: matrix_q[2] <= cfg_data;
				REG_ROW3: matrix_q[3] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign matrix = matrix_q;

endmodule

### design/afc_xform.sv
// Corner transform: products, partial sums and the 32 clip coordinates.
// Depends on afc_pkg; stages 1 to 3 of the pipeline.
module afc_xform #(
	parameter int COORD_BITS = 16
) (
	input  logic                                         clk,
	input  afc_pkg::afc_adv_t                            adv,
	input  afc_pkg::mat_t                                matrix,
	input  logic signed [COORD_BITS-1:0]                 box_lo [afc_pkg::AXES],
	input  logic signed [COORD_BITS-1:0]                 box_hi [afc_pkg::AXES],
	output logic signed [COORD_BITS+afc_pkg::MAT_W+1:0]  clip_s3
		[afc_pkg::ROWS][afc_pkg::CORNERS]
);
	import afc_pkg::*;

	localparam int PROD_W = COORD_BITS + MAT_W;
	localparam int CLIP_W = COORD_BITS + MAT_W + 2;

	logic signed [PROD_W-1:0] prod_s1 [ROWS][AXES][2];
	logic signed [CLIP_W-1:0] xy_s2   [ROWS][4];
	logic signed [CLIP_W-1:0] zc_s2   [ROWS][2];

	// Stage 1: each entry times the minimum and the maximum of its axis.
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			for (int r = 0; r < ROWS; r++) begin
				for (int a = 0; a < AXES; a++) begin
					prod_s1[r][a][0] <= PROD_W'(mat_entry(matrix[r], a)) * PROD_W'(box_lo[a]);
					prod_s1[r][a][1] <= PROD_W'(mat_entry(matrix[r], a)) * PROD_W'(box_hi[a]);
				end
			end
		end
	end

	// Stage 2: x plus y for the four xy choices, z plus the translation entry.
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			for (int r = 0; r < ROWS; r++) begin
				for (int c = 0; c < 4; c++) begin
					xy_s2[r][c] <= CLIP_W'(prod_s1[r][0][c & 1])
						+ CLIP_W'(prod_s1[r][1][(c >> 1) & 1]);
				end
				for (int h = 0; h < 2; h++) begin
					zc_s2[r][h] <= CLIP_W'(prod_s1[r][2][h])
						+ CLIP_W'(mat_entry(matrix[r], COLS - 1));
				end
			end
		end
	end

	// Stage 3: full clip coordinate of every row for every corner.
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			for (int r = 0; r < ROWS; r++) begin
				for (int k = 0; k < CORNERS; k++) begin
					clip_s3[r][k] <= xy_s2[r][k & 3] + zc_s2[r][(k >> 2) & 1];
				end
			end
		end
	end

endmodule

### design/afc_test.sv
// Clip-space inside test for each corner and the reduction to one flag.
// Depends on afc_pkg; stages 4 and 5 of the pipeline.
module afc_test #(
	parameter int COORD_BITS = 16
) (
	input  logic                                         clk,
	input  afc_pkg::afc_adv_t                            adv,
	input  logic signed [COORD_BITS+afc_pkg::MAT_W+1:0]  clip_s3
		[afc_pkg::ROWS][afc_pkg::CORNERS],
	output logic                                         visible_s5
);
	import afc_pkg::*;

	localparam int CLIP_W = COORD_BITS + MAT_W + 2;

	logic [CORNERS-1:0] inside_s4;

	// True when -w <= v <= w, done as two sign checks one bit wider.
	function automatic logic in_range(input logic signed [CLIP_W-1:0] v,
	                                  input logic signed [CLIP_W-1:0] w);
		logic signed [CLIP_W:0] lo_gap;
		logic signed [CLIP_W:0] hi_gap;
		lo_gap   = (CLIP_W+1)'(w) + (CLIP_W+1)'(v);
		hi_gap   = (CLIP_W+1)'(w) - (CLIP_W+1)'(v);
		in_range = !lo_gap[CLIP_W] && !hi_gap[CLIP_W];
	endfunction

	// Stage 4: a corner counts only with positive w and all three axes in range.
	always_ff @(posedge clk) begin
		if (adv.s4) begin
			for (int k = 0; k < CORNERS; k++) begin
				inside_s4[k] <= (clip_s3[ROW_W][k] > 0)
					&& in_range(clip_s3[0][k], clip_s3[ROW_W][k])
					&& in_range(clip_s3[1][k], clip_s3[ROW_W][k])
					&& in_range(clip_s3[2][k], clip_s3[ROW_W][k]);
			end
		end
	end

	// Stage 5: the box is visible when any corner is inside.
	always_ff @(posedge clk) begin
		if (adv.s5) begin
			visible_s5 <= |inside_s4;
		end
	end

endmodule

### design/aabb_frustum_cull_top.sv
// Top level of the box frustum culling pipeline: stream ports and stage control.
// Depends on afc_pkg, afc_cfg, afc_xform and afc_test.
//
// Takes one axis-aligned box per clock unless a stalled output backs up the pipeline,
// and returns one visible flag per box, in order. Each box passes through the five
// register stages and its flag is presented from the last. The 24 multipliers of
// the first stage (four matrix rows times three axes times minimum and maximum)
// all work in parallel, and the five register stages each hold their own valid
// bit, so a stalled output only halts the stages that are full. The matrix is
// all zero after reset, which reports every box as not visible; write it only
// while no box is in flight.
module aabb_frustum_cull_top #(
	parameter int COORD_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// From bit 0 up: box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
	input  logic [((6*COORD_BITS+7)/8)*8-1:0]   s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// Bit 0: visible; upper bits zero
	output logic [7:0]                          m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [afc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [afc_pkg::CFG_W-1:0]           cfg_data
);
	import afc_pkg::*;

	localparam int CLIP_W = COORD_BITS + MAT_W + 2;

	mat_t     matrix;
	afc_adv_t adv;

	logic signed [COORD_BITS-1:0] box_lo [AXES];
	logic signed [COORD_BITS-1:0] box_hi [AXES];
	logic signed [CLIP_W-1:0]     clip_s3 [ROWS][CORNERS];
	logic                         visible_s5;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;

	afc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.matrix    (matrix)
	);

	// Unpack the box corners from the input request.
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			box_lo[a] = $signed(s_axis_tdata[a*COORD_BITS +: COORD_BITS]);
			box_hi[a] = $signed(s_axis_tdata[(a+AXES)*COORD_BITS +: COORD_BITS]);
		end
	end

	// A stage loads when it is empty or the stage after it moves on.
	always_comb begin
		adv.s5 = !v_s5 || m_axis_tready;
		adv.s4 = !v_s4 || adv.s5;
		adv.s3 = !v_s3 || adv.s4;
		adv.s2 = !v_s2 || adv.s3;
		adv.s1 = !v_s1 || adv.s2;
	end

	assign s_axis_tready = adv.s1;

	// Valid bits travel alongside the datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv.s1) v_s1 <= s_axis_tvalid;
			if (adv.s2) v_s2 <= v_s1;
			if (adv.s3) v_s3 <= v_s2;
			if (adv.s4) v_s4 <= v_s3;
			if (adv.s5) v_s5 <= v_s4;
		end
	end

	afc_xform #(
		.COORD_BITS (COORD_BITS)
	) u_xform (
		.clk     (clk),
		.adv     (adv),
		.matrix  (matrix),
		.box_lo  (box_lo),
		.box_hi  (box_hi),
		.clip_s3 (clip_s3)
	);

	afc_test #(
		.COORD_BITS (COORD_BITS)
	) u_test (
		.clk        (clk),
		.adv        (adv),
		.clip_s3    (clip_s3),
		.visible_s5 (visible_s5)
	);

	// The last stage is the output register.
	assign m_axis_tvalid = v_s5;
	assign m_axis_tdata  = {7'd0, visible_s5};

endmodule
